/* design/csim_pkg.sv */
`default_nettype none

package csim_pkg;

   localparam int TASK_ID_W   = 16;
   localparam int CPU_IDX_W   = 3;
   localparam int CNT_W       = 32;
   localparam int THRESHOLD_W = 16;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'h8000;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_CLOSE = 1'b1;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic                 cmd;
      logic [CPU_IDX_W-1:0] cpu_index;
      logic                 task_present;
      logic [TASK_ID_W-1:0] task_id;
      logic                 first_tick;
   } req_type;

   typedef struct packed {
      logic [CPU_IDX_W-1:0] out_cpu;
      logic                 switched;
      cnt_type              switch_count;
      cnt_type              idle_period_count;
      cnt_type              idle_run_length;
   } rsp_type;

   // per-cpu counters, moved between the state file and the update logic
   typedef struct packed {
      cnt_type switches;
      cnt_type periods;
      cnt_type ticks;
   } cnt_set_type;

   function automatic cnt_type sat_inc(input cnt_type v);
      cnt_type r;
      r = (v == '1) ? v : v + cnt_type'(1);
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/csim_req_if.sv */
`default_nettype none

interface csim_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 cmd;
   logic [csim_pkg::CPU_IDX_W-1:0]       cpu_index;
   logic                                 task_present;
   logic [csim_pkg::TASK_ID_W-1:0]       task_id;
   logic                                 first_tick;

   modport source (
      output valid, cmd, cpu_index, task_present, task_id, first_tick,
      input  ready
   );

   modport sink (
      input  valid, cmd, cpu_index, task_present, task_id, first_tick,
      output ready
   );
endinterface

`default_nettype wire

/* design/csim_rsp_if.sv */
`default_nettype none

interface csim_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [csim_pkg::CPU_IDX_W-1:0] out_cpu;
   logic                           switched;
   csim_pkg::cnt_type              switch_count;
   csim_pkg::cnt_type              idle_period_count;
   csim_pkg::cnt_type              idle_run_length;

   modport source (
      output valid, out_cpu, switched, switch_count, idle_period_count, idle_run_length,
      input  ready
   );

   modport sink (
      input  valid, out_cpu, switched, switch_count, idle_period_count, idle_run_length,
      output ready
   );
endinterface

`default_nettype wire

/* design/csim_state_file.sv */
`default_nettype none

module csim_state_file #(
   parameter int NUM_CPUS = 8,
   parameter int IDX_W    = 3,
   parameter int ID_W     = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [IDX_W-1:0]      rd_idx,
   output      logic                  rd_last_valid,
   output      logic [ID_W-1:0]       rd_last_id,
   output      logic                  rd_prior_valid,
   output      logic [ID_W-1:0]       rd_prior_id,
   output      csim_pkg::cnt_set_type rd_cnt,
   input  wire logic                  wr_en,
   input  wire logic [IDX_W-1:0]      wr_idx,
   input  wire logic                  wr_last_valid,
   input  wire logic [ID_W-1:0]       wr_last_id,
   input  wire logic                  wr_prior_valid,
   input  wire logic [ID_W-1:0]       wr_prior_id,
   input  wire csim_pkg::cnt_set_type wr_cnt
);

   logic                  last_valid_ff  [NUM_CPUS];
   logic [ID_W-1:0]       last_id_ff     [NUM_CPUS];
   logic                  prior_valid_ff [NUM_CPUS];
   logic [ID_W-1:0]       prior_id_ff    [NUM_CPUS];
   csim_pkg::cnt_set_type cnt_ff         [NUM_CPUS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CPUS; i++) begin
            last_valid_ff[i]  <= 1'b0;
            prior_valid_ff[i] <= 1'b0;
            cnt_ff[i]         <= '0;
         end
      end else if (wr_en) begin
         last_valid_ff[wr_idx]  <= wr_last_valid;
         prior_valid_ff[wr_idx] <= wr_prior_valid;
         cnt_ff[wr_idx]         <= wr_cnt;
      end
   end

   // ids are only meaningful while their valid bit is set
   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_id_ff[wr_idx]  <= wr_last_id;
         prior_id_ff[wr_idx] <= wr_prior_id;
      end
   end

   assign rd_last_valid  = last_valid_ff[rd_idx];
   assign rd_last_id     = last_id_ff[rd_idx];
   assign rd_prior_valid = prior_valid_ff[rd_idx];
   assign rd_prior_id    = prior_id_ff[rd_idx];
   assign rd_cnt         = cnt_ff[rd_idx];

endmodule

`default_nettype wire

/* design/csim_update.sv */
`default_nettype none

module csim_update #(
   parameter int ID_W = 16
) (
   input  wire csim_pkg::req_type                    item,
   input  wire logic [csim_pkg::THRESHOLD_W-1:0]     threshold,
   input  wire logic                                 last_valid,
   input  wire logic [ID_W-1:0]                      last_id,
   input  wire logic                                 prior_valid,
   input  wire logic [ID_W-1:0]                      prior_id,
   input  wire csim_pkg::cnt_set_type                cnt,
   output      logic                                 nxt_last_valid,
   output      logic [ID_W-1:0]                      nxt_last_id,
   output      logic                                 nxt_prior_valid,
   output      logic [ID_W-1:0]                      nxt_prior_id,
   output      csim_pkg::cnt_set_type                nxt_cnt,
   output      logic                                 switched
);

   logic [ID_W-1:0] cur_id;
   logic            cur_idle;
   logic            was_idle;
   logic            same_prior;
   logic            same_last;

   assign cur_id   = item.task_present ? ID_W'(item.task_id) : '0;
   assign cur_idle = !item.task_present ||
                     (csim_pkg::THRESHOLD_W'(cur_id) >= threshold);
   assign was_idle = !last_valid || (csim_pkg::THRESHOLD_W'(last_id) >= threshold);

   assign same_prior = (item.task_present == prior_valid) &&
                       (!item.task_present || cur_id == prior_id);
   assign same_last  = (item.task_present == last_valid) &&
                       (!item.task_present || cur_id == last_id);

   always_comb begin
      nxt_last_valid  = last_valid;
      nxt_last_id     = last_id;
      nxt_prior_valid = prior_valid;
      nxt_prior_id    = prior_id;
      nxt_cnt         = cnt;
      switched        = 1'b0;

      if (item.cmd == csim_pkg::CMD_CLOSE) begin
         if (was_idle && cnt.ticks > csim_pkg::cnt_type'(1)) begin
            nxt_cnt.periods = csim_pkg::sat_inc(cnt.periods);
         end
      end else begin
         if (!cur_idle) begin
            if (was_idle) begin
               // returning from idle: compare against the task before the idle run
               switched = !same_prior;
               if (!item.first_tick) begin
                  if (cnt.ticks != csim_pkg::cnt_type'(1)) begin
                     nxt_cnt.periods = csim_pkg::sat_inc(cnt.periods);
                  end
                  nxt_cnt.ticks = '0;
               end
            end else begin
               switched = (cur_id != last_id);
            end
         end else begin
            nxt_cnt.ticks = csim_pkg::sat_inc(cnt.ticks);
         end

         if (switched) begin
            nxt_cnt.switches = csim_pkg::sat_inc(cnt.switches);
         end
         if (!same_last) begin
            nxt_prior_valid = last_valid;
            nxt_prior_id    = last_id;
         end
         nxt_last_valid = item.task_present;
         nxt_last_id    = cur_id;
      end
   end

endmodule

`default_nettype wire

/* design/cpu_context_switch_idle_monitor.sv */
// An accepted item is held in the input register in_ff, then moves on to the result
// register rsp_ff, which drives rsp_if.
// Throughput: one item per cycle unless rsp_if stalls; the per-cpu register file is read, updated
// and written back within the single pass between the input and result registers.
// Reset (synchronous): clears all counters and task history of every cpu, empties
// both pipeline registers and sets the idle threshold to 32768.
`default_nettype none

module cpu_context_switch_idle_monitor #(
   parameter int NUM_CPUS     = 8,
   parameter int TASK_ID_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   csim_req_if.sink                                req_if,
   csim_rsp_if.source                              rsp_if,
   input  wire logic                               csr_wr_en,
   input  wire logic [csim_pkg::THRESHOLD_W-1:0]   csr_wr_data
);

   localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int ID_W  = (TASK_ID_BITS < csim_pkg::TASK_ID_W) ?
                          TASK_ID_BITS : csim_pkg::TASK_ID_W;

   logic [csim_pkg::THRESHOLD_W-1:0] threshold_ff;

   logic              in_valid_ff;
   logic              in_valid_in;
   csim_pkg::req_type in_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   csim_pkg::rsp_type rsp_ff;
   csim_pkg::rsp_type rsp_in;

   logic advance;
   logic req_take;
   logic in_range;
   logic state_we;
   logic [IDX_W-1:0] idx;

   logic                  rd_last_valid;
   logic [ID_W-1:0]       rd_last_id;
   logic                  rd_prior_valid;
   logic [ID_W-1:0]       rd_prior_id;
   csim_pkg::cnt_set_type rd_cnt;
   logic                  wr_last_valid;
   logic [ID_W-1:0]       wr_last_id;
   logic                  wr_prior_valid;
   logic [ID_W-1:0]       wr_prior_id;
   csim_pkg::cnt_set_type wr_cnt;
   logic                  switched;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= csim_pkg::THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   // result register frees up when empty or being taken
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.cmd          <= req_if.cmd;
         in_ff.cpu_index    <= req_if.cpu_index;
         in_ff.task_present <= req_if.task_present;
         in_ff.task_id      <= req_if.task_id;
         in_ff.first_tick   <= req_if.first_tick;
      end
   end

   assign in_range = (int'(in_ff.cpu_index) < NUM_CPUS);
   assign idx      = IDX_W'(in_ff.cpu_index);
   assign state_we = advance && in_valid_ff && in_range;

   csim_state_file #(
      .NUM_CPUS (NUM_CPUS),
      .IDX_W    (IDX_W),
      .ID_W     (ID_W)
   ) u_state_file (
      .clock          (clock),
      .reset          (reset),
      .rd_idx         (idx),
      .rd_last_valid  (rd_last_valid),
      .rd_last_id     (rd_last_id),
      .rd_prior_valid (rd_prior_valid),
      .rd_prior_id    (rd_prior_id),
      .rd_cnt         (rd_cnt),
      .wr_en          (state_we),
      .wr_idx         (idx),
      .wr_last_valid  (wr_last_valid),
      .wr_last_id     (wr_last_id),
      .wr_prior_valid (wr_prior_valid),
      .wr_prior_id    (wr_prior_id),
      .wr_cnt         (wr_cnt)
   );

   csim_update #(
      .ID_W (ID_W)
   ) u_update (
      .item            (in_ff),
      .threshold       (threshold_ff),
      .last_valid      (rd_last_valid),
      .last_id         (rd_last_id),
      .prior_valid     (rd_prior_valid),
      .prior_id        (rd_prior_id),
      .cnt             (rd_cnt),
      .nxt_last_valid  (wr_last_valid),
      .nxt_last_id     (wr_last_id),
      .nxt_prior_valid (wr_prior_valid),
      .nxt_prior_id    (wr_prior_id),
      .nxt_cnt         (wr_cnt),
      .switched        (switched)
   );

   // a cpu outside the file reports its index with no switch and zero counts
   always_comb begin
      rsp_in         = '0;
      rsp_in.out_cpu = in_ff.cpu_index;
      if (in_range) begin
         rsp_in.switched          = switched;
         rsp_in.switch_count      = wr_cnt.switches;
         rsp_in.idle_period_count = wr_cnt.periods;
         rsp_in.idle_run_length   = wr_cnt.ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.out_cpu           = rsp_ff.out_cpu;
   assign rsp_if.switched          = rsp_ff.switched;
   assign rsp_if.switch_count      = rsp_ff.switch_count;
   assign rsp_if.idle_period_count = rsp_ff.idle_period_count;
   assign rsp_if.idle_run_length   = rsp_ff.idle_run_length;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_stalled_item_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("stalled input item lost or changed");

   a_switch_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.switched |-> rsp_ff.switch_count != '0)
      else $error("switch reported with zero switch count");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (int'(rsp_ff.out_cpu) >= NUM_CPUS) |->
         !rsp_ff.switched && rsp_ff.switch_count == '0 &&
         rsp_ff.idle_period_count == '0 && rsp_ff.idle_run_length == '0)
      else $error("result for missing cpu is not zero");

endmodule

`default_nettype wire
